// ===== src/sfcc_pkg.sv =====
package sfcc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [2:0]  POS_MAX = 3'd7;
   localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

   typedef enum logic [1:0] {
      VERDICT_GOOD    = 2'd0,
      VERDICT_BAD_LEN = 2'd1,
      VERDICT_BAD_CRC = 2'd2
   } verdict_type;

   typedef struct packed {
      verdict_type verdict;
      logic [3:0]  device_code;
   } result_type;

   // Reflected CRC-16/MODBUS update over one byte, LSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== src/status_frame_crc_checker.sv =====
// Status frame CRC checker.
// Input channel (req_): one beat per frame byte, req_tlast on the final byte.
// Result channel (rsp_): exactly one beat per frame, sent for its tlast byte,
// carrying the verdict (good, wrong length, CRC mismatch) and, for a good
// frame, the low nibble of the status byte.
// The CRC-16/MODBUS update for a byte is combinational, so a byte is taken
// every cycle while req_tready is high: throughput 1 byte/cycle. A verdict
// goes into a registered output queue entry when its last byte is accepted.
// Verdicts go into a two-entry output queue; req_tready falls only when both
// entries hold untaken verdicts, so a stalled receiver backs up the input
// only after two pending results. Non-last bytes never produce a beat.
// Reset (synchronous, active high) empties the queue, restarts the frame
// (CRC 0xFFFF, position zero) and clears the stored status and CRC bytes.
// Frames longer than eight bytes saturate the byte count and report wrong
// length. FRAME_LEN may be 3 to 6.
module status_frame_crc_checker #(
   parameter int FRAME_LEN = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] frame_verdict, [5:2] device_code, [7:6] zero
);
   import sfcc_pkg::*;

   logic       beat_valid;
   logic       result_valid;
   result_type result;
   result_type out_result;

   assign beat_valid = req_tvalid && req_tready;

   sfcc_frame #(
      .FRAME_LEN(FRAME_LEN)
   ) u_frame (
      .clock(clock),
      .reset(reset),
      .beat_valid(beat_valid),
      .rx_byte(req_tdata),
      .last_byte(req_tlast),
      .result_valid(result_valid),
      .result(result)
   );

   sfcc_out_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(result_valid),
      .push_data(result),
      .has_space(req_tready),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data(out_result)
   );

   assign rsp_tdata = {2'b00, out_result.device_code, out_result.verdict};

endmodule

// ===== src/sfcc_frame.sv =====
module sfcc_frame #(
   parameter int FRAME_LEN = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat_valid,
   input  logic [7:0]           rx_byte,
   input  logic                 last_byte,
   output logic                 result_valid,
   output sfcc_pkg::result_type result
);
   import sfcc_pkg::*;

   localparam logic [2:0] CRC_LOW_POS = 3'(FRAME_LEN - 2);
   localparam logic [2:0] LAST_POS = 3'(FRAME_LEN - 1);

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] rx_crc;

   assign rx_crc = {rx_byte, crc_low_ff};

   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      status_in = status_ff;
      crc_low_in = crc_low_ff;
      result_valid = 1'b0;
      result.verdict = VERDICT_GOOD;
      result.device_code = '0;
      if (beat_valid) begin
         if (!last_byte) begin
            if (pos_ff < CRC_LOW_POS) begin
               crc_in = crc16_byte(crc_ff, rx_byte);
            end
            if (pos_ff == 3'd1) begin
               status_in = rx_byte;
            end
            if (pos_ff == CRC_LOW_POS) begin
               crc_low_in = rx_byte;
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 3'd1;
            end
         end else begin
            result_valid = 1'b1;
            if (pos_ff != LAST_POS) begin
               result.verdict = VERDICT_BAD_LEN;
            end else if (rx_crc != crc_ff) begin
               result.verdict = VERDICT_BAD_CRC;
            end else begin
               result.device_code = 4'(status_ff & NIBBLE_MASK);
            end
            // restart frame
            crc_in = CRC_INIT;
            pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         pos_ff <= '0;
         status_ff <= '0;
         crc_low_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         status_ff <= status_in;
         crc_low_ff <= crc_low_in;
      end
   end

endmodule

// ===== src/sfcc_out_queue.sv =====
module sfcc_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfcc_pkg::result_type push_data,
   output logic                 has_space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sfcc_pkg::result_type out_data
);
   import sfcc_pkg::*;

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign has_space = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data = entry_ff[rd_ptr_ff];
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/sfcc_checker.sv =====
module sfcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 && rsp_tdata[7:6] == 2'd0)
      else $error("undefined verdict or padding set");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[5:2] == 4'd0)
      else $error("device code set on a failed frame");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready && req_tlast) |=> !rsp_tvalid)
      else $error("result beat without a last byte");

endmodule

bind status_frame_crc_checker sfcc_checker u_sfcc_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tlast(req_tlast),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
